// ===== hdl/luhn_card_brand_checker_defines.svh =====
// ---------------------------------------------------------------------------
// Luhn card brand checker assertion macros
// Shared property wrappers for the checker's concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef LUHN_CARD_BRAND_CHECKER_DEFINES_SVH
`define LUHN_CARD_BRAND_CHECKER_DEFINES_SVH

// Same-cycle implication, muted during reset.
`define LCBC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcbc same-cycle check failed");

// Next-cycle implication, muted during reset.
`define LCBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcbc next-cycle check failed");

`endif

// ===== hdl/lcbc_pkg.sv =====
// ---------------------------------------------------------------------------
// Luhn card brand checker package
// Widths, result codes and the result word shared by the checker modules.
// ---------------------------------------------------------------------------
package lcbc_pkg;

   localparam int unsigned NUM_W      = 63;            // card number width
   localparam int unsigned NUM_DIGITS = 19;            // decimal digits of 2^63-1
   localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 8;

   typedef enum logic [1:0] {
      CLASS_INVALID    = 2'd0,
      CLASS_VISA       = 2'd1,
      CLASS_AMEX       = 2'd2,
      CLASS_MASTERCARD = 2'd3
   } card_class_type;

   typedef struct packed {
      logic           luhn_ok;
      logic [4:0]     digit_count;
      card_class_type card_class;
   } result_type;

endpackage

// ===== hdl/lcbc_queue.sv =====
// ---------------------------------------------------------------------------
// Luhn card brand checker input queue
// Front part: takes card number words and buffers them for the engine.
// ---------------------------------------------------------------------------
module lcbc_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   output logic                         push_ready,
   input  logic [lcbc_pkg::NUM_W-1:0]   push_data,
   output logic                         pop_valid,
   input  logic                         pop_ready,
   output logic [lcbc_pkg::NUM_W-1:0]   pop_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [lcbc_pkg::NUM_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]           fill_ff, fill_in;
   logic                       push, pop;

   assign push_ready = (fill_ff != CNT_W'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/lcbc_engine.sv =====
// ---------------------------------------------------------------------------
// Luhn card brand checker engine
// Back part: bit-serial binary to BCD, digit scan for Luhn and brand.
// ---------------------------------------------------------------------------
`include "luhn_card_brand_checker_defines.svh"

module lcbc_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_valid,
   output logic                        job_ready,
   input  logic [lcbc_pkg::NUM_W-1:0]  job_number,
   output logic                        res_valid,
   input  logic                        res_ready,
   output lcbc_pkg::result_type        res_word
);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_CONVERT = 4'b0010,
      ST_SCAN    = 4'b0100,
      ST_FINISH  = 4'b1000
   } state_type;

   localparam logic [5:0] LAST_BIT   = 6'(lcbc_pkg::NUM_W - 1);
   localparam logic [5:0] LAST_DIGIT = 6'(lcbc_pkg::NUM_DIGITS - 1);

   state_type                      state_ff, state_in;
   logic [5:0]                     step_ff, step_in;
   logic [lcbc_pkg::NUM_W-1:0]     shreg_ff, shreg_in;
   logic [lcbc_pkg::BCD_W-1:0]     bcd_ff, bcd_in;
   logic [lcbc_pkg::BCD_W-1:0]     bcd_adj;
   logic [3:0]                     total_ff, total_in;
   logic [4:0]                     count_ff, count_in;
   logic [3:0]                     lead_ff, lead_in;
   logic [3:0]                     second_ff, second_in;
   logic [3:0]                     prev_ff, prev_in;
   logic                           res_valid_ff, res_valid_in;
   lcbc_pkg::result_type           res_ff, res_in;
   logic [3:0]                     digit;
   logic [3:0]                     contrib;
   logic [4:0]                     sum;
   logic                           luhn_ok;
   lcbc_pkg::card_class_type       cls;

   assign job_ready = (state_ff == ST_IDLE);
   assign res_valid = res_valid_ff;
   assign res_word  = res_ff;

   // add-3 correction on every BCD digit before the shift
   always_comb begin
      for (int i = 0; i < lcbc_pkg::NUM_DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                         : bcd_ff[4*i +: 4];
      end
   end

   // Luhn term of the digit under scan, total kept mod 10
   assign digit   = bcd_ff[3:0];
   assign contrib = !step_ff[0] ? digit :
                    (digit < 4'd5) ? {digit[2:0], 1'b0} : 4'({digit, 1'b0} - 5'd9);
   assign sum     = {1'b0, total_ff} + {1'b0, contrib};

   assign luhn_ok = (total_ff == 4'd0);

   always_comb begin
      cls = lcbc_pkg::CLASS_INVALID;
      if (luhn_ok) begin
         if ((count_ff == 5'd13 || count_ff == 5'd16) && lead_ff == 4'd4) begin
            cls = lcbc_pkg::CLASS_VISA;
         end else if (count_ff == 5'd15 && lead_ff == 4'd3 &&
                      (second_ff inside {4'd4, 4'd7})) begin
            cls = lcbc_pkg::CLASS_AMEX;
         end else if (count_ff == 5'd16 && lead_ff == 4'd5 &&
                      (second_ff inside {[4'd1:4'd5]})) begin
            cls = lcbc_pkg::CLASS_MASTERCARD;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      shreg_in     = shreg_ff;
      bcd_in       = bcd_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      lead_in      = lead_ff;
      second_in    = second_ff;
      prev_in      = prev_ff;
      res_in       = res_ff;
      res_valid_in = res_valid_ff;

      if (res_valid_ff && res_ready) begin
         res_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               shreg_in = job_number;
               bcd_in   = '0;
               step_in  = '0;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            bcd_in   = {bcd_adj[lcbc_pkg::BCD_W-2:0], shreg_ff[lcbc_pkg::NUM_W-1]};
            shreg_in = {shreg_ff[lcbc_pkg::NUM_W-2:0], 1'b0};
            step_in  = step_ff + 6'd1;
            if (step_ff == LAST_BIT) begin
               step_in   = '0;
               total_in  = '0;
               count_in  = '0;
               lead_in   = '0;
               second_in = '0;
               prev_in   = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            bcd_in   = {4'd0, bcd_ff[lcbc_pkg::BCD_W-1:4]};
            total_in = (sum >= 5'd10) ? 4'(sum - 5'd10) : sum[3:0];
            prev_in  = digit;
            if (digit != 4'd0) begin
               count_in  = 5'(step_ff + 6'd1);
               lead_in   = digit;
               second_in = prev_ff;
            end
            step_in = step_ff + 6'd1;
            if (step_ff == LAST_DIGIT) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the result slot is free
            if (!res_valid_ff || res_ready) begin
               res_in.card_class  = cls;
               res_in.digit_count = count_ff;
               res_in.luhn_ok     = luhn_ok;
               res_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shreg_ff  <= shreg_in;
      bcd_ff    <= bcd_in;
      total_ff  <= total_in;
      count_ff  <= count_in;
      lead_ff   <= lead_in;
      second_ff <= second_in;
      prev_ff   <= prev_in;
      res_ff    <= res_in;
   end

   `LCBC_ASSERT_IMPLIES(a_brand_needs_luhn, clock, reset, res_valid_ff && res_ff.card_class != lcbc_pkg::CLASS_INVALID, res_ff.luhn_ok)
   `LCBC_ASSERT_IMPLIES(a_visa_length, clock, reset, res_valid_ff && res_ff.card_class == lcbc_pkg::CLASS_VISA, res_ff.digit_count == 5'd13 || res_ff.digit_count == 5'd16)
   `LCBC_ASSERT_IMPLIES(a_count_range, clock, reset, res_valid_ff, res_ff.digit_count <= 5'd19)
   `LCBC_ASSERT_NEXT(a_scan_follows_convert, clock, reset, state_ff == ST_CONVERT && step_ff == LAST_BIT, state_ff == ST_SCAN && step_ff == 6'd0)

endmodule

// ===== hdl/luhn_card_brand_checker.sv =====
// ---------------------------------------------------------------------------
// Luhn card brand checker
// Luhn mod-10 check and card brand decode of a binary card number.
// ---------------------------------------------------------------------------
// Each word on the req_ channel carries one card number as an unsigned binary
// integer; each word on the rsp_ channel returns its brand (invalid, visa,
// amex, mastercard), its decimal digit count and the Luhn pass flag, one
// result per number, in order. Incoming words land in a small queue
// (QUEUE_DEPTH entries) so the port keeps taking numbers while the engine is
// busy. The engine handles one number at a time: it takes the number from the
// queue, converts it bit-serially from binary to BCD, scans one digit a cycle
// for the Luhn total, digit count and leading digits, and posts the result. A
// finished result sits in its own output register, so the engine starts on the
// next number while the result waits; it stalls only when a second result is
// ready before the first is taken. Zero has no digits: it reports count 0, Luhn
// pass, class invalid.
// ---------------------------------------------------------------------------
module luhn_card_brand_checker #(
   parameter int unsigned QUEUE_DEPTH = 2   // 2 to 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lcbc_pkg::REQ_DATA_W-1:0]   req_tdata,   // [62:0] card_number, [63] zero
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lcbc_pkg::RSP_DATA_W-1:0]   rsp_tdata    // [1:0] card_class,
                                                          // [6:2] digit_count, [7] luhn_ok
);

   logic                        job_valid;
   logic                        job_ready;
   logic [lcbc_pkg::NUM_W-1:0]  job_number;
   lcbc_pkg::result_type        res_word;

   // front: buffer numbers; the pad bit above the number is dropped
   lcbc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_data  (req_tdata[lcbc_pkg::NUM_W-1:0]),
      .pop_valid  (job_valid),
      .pop_ready  (job_ready),
      .pop_data   (job_number)
   );

   // back: convert, scan and classify; holds the result in its output register
   lcbc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job_number (job_number),
      .res_valid  (rsp_tvalid),
      .res_ready  (rsp_tready),
      .res_word   (res_word)
   );

   // pack with card_class in the lowest bits
   assign rsp_tdata = {res_word.luhn_ok, res_word.digit_count, res_word.card_class};

endmodule
